[rtl/core/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared field widths, action codes, status codes and register indexes of
// the bitmap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 3;
    localparam int PHYS_ADDR_W   = 64;
    localparam int CFG_COUNT_W   = 13;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 4;

    localparam logic [CFG_COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

    // action codes carried on s_tuser
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM          = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED      = 3'd5;

    // register index, taken from paddr bit 3 (registers sit 8 bytes apart)
    localparam logic REG_REGION_BASE = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

endpackage

`default_nettype wire

[rtl/core/bitmap_frame_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page frame allocator over a bitmap held in one synchronous memory of
// WORD_BITS-bit words, one bit per frame, 1 meaning allocated. A request
// carries an action on s_tuser: allocate takes the lowest clear frame below
// min(frame_count, FRAMES_MAX) and returns region_base + index * page size;
// free turns an address into a frame index and clears its bit; clear empties
// the bitmap. Requests are handled one at a time, one result per request.
// Allocate reads one bitmap word per cycle through the memory read port.
// Free splits the frame index into word and bit with a shift and a mask,
// so WORD_BITS must be a power of two. Clear writes one word per cycle.
// s_tready returns in the cycle the result is loaded into the output
// register; a stalled result holds the block until the output register
// frees up. After reset the same clearing pass runs over every bitmap
// word before the first request is taken; configuration writes are
// taken at all times.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int FRAMES_MAX = 4096,
    parameter int WORD_BITS  = 64,
    parameter int PAGE_SHIFT = 12
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    // request channel
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [PHYS_ADDR_W-1:0] s_tdata,   // [63:0] frame_address
    input  wire  [ACTION_W-1:0]    s_tuser,   // [1:0] action
    // result channel
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [PHYS_ADDR_W-1:0] m_tdata,   // [63:0] result_address
    output logic [STATUS_W-1:0]    m_tuser,   // [2:0] status
    // configuration
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [CFG_ADDR_W-1:0]  paddr,
    input  wire  [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int WORD_COUNT = (FRAMES_MAX + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = $clog2(FRAMES_MAX + 1);
    localparam int BASE_W     = $clog2(FRAMES_MAX + WORD_BITS + 1);

    localparam logic [WADDR_W-1:0] END_WORD = WADDR_W'(WORD_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FCHK,
        S_FRD,
        S_FMOD,
        S_DONE
    } state_t;

    // bitmap memory
    logic [WORD_BITS-1:0] frame_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] mem_rdata_reg;
    logic                 mem_we;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_raddr;

    state_t state_reg, state_next;

    logic [PHYS_ADDR_W-1:0] region_base_reg, region_base_next;
    logic [CFG_COUNT_W-1:0] frame_count_reg, frame_count_next;

    logic [WADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                   clr_report_reg, clr_report_next;

    logic [WADDR_W-1:0]     rd_word_reg, rd_word_next;
    logic [BASE_W-1:0]      rd_base_reg, rd_base_next;
    logic [WADDR_W-1:0]     ev_word_reg, ev_word_next;
    logic [BASE_W-1:0]      ev_base_reg, ev_base_next;
    logic                   ev_valid_reg, ev_valid_next;

    logic [PHYS_ADDR_W-1:0] fdiff_reg, fdiff_next;
    logic                   fge_reg, fge_next;
    logic [CNT_W-1:0]       quot_reg, quot_next;
    logic [BIT_W-1:0]       rem_reg, rem_next;

    logic [PHYS_ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [STATUS_W-1:0]    pend_status_reg, pend_status_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [PHYS_ADDR_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [CNT_W-1:0]       eff_count;
    logic                   cfg_we;
    logic                   out_free;
    logic                   issue;
    logic [BASE_W-1:0]      rem_frames;
    logic [BIT_W:0]         rem_sat;
    logic [WORD_BITS-1:0]   valid_mask;
    logic [WORD_BITS-1:0]   free_bits;
    logic                   found;
    logic [BIT_W-1:0]       found_pos;
    logic [BASE_W-1:0]      res_idx;
    logic [PHYS_ADDR_W-1:0] alloc_addr;
    logic [PHYS_ADDR_W:0]   sub_wide;
    logic [PHYS_ADDR_W-1:0] free_idx;
    logic                   free_in_range;

    // ------------------------------------------------------------------
    // bitmap memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= frame_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    always_comb begin
        if (32'(frame_count_reg) > 32'(FRAMES_MAX)) begin
            eff_count = CNT_W'(FRAMES_MAX);
        end else begin
            eff_count = CNT_W'(frame_count_reg);
        end
    end

    assign cfg_we   = psel & penable & pwrite;
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = rd_base_reg < BASE_W'(eff_count);

    // limit the scan to frames below the effective count
    assign rem_frames = BASE_W'(eff_count) - ev_base_reg;
    assign rem_sat    = (rem_frames >= BASE_W'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS)
                                                           : rem_frames[BIT_W:0];
    assign valid_mask = ~({WORD_BITS{1'b1}} << rem_sat);
    assign free_bits  = ~mem_rdata_reg & valid_mask;
    assign found      = |free_bits;

    always_comb begin
        found_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found_pos = BIT_W'(b);
            end
        end
    end

    assign res_idx    = ev_base_reg + BASE_W'(found_pos);
    assign alloc_addr = region_base_reg + (PHYS_ADDR_W'(res_idx) << PAGE_SHIFT);

    // borrow of the subtraction tells an address below the base
    assign sub_wide      = {1'b0, s_tdata} - {1'b0, region_base_reg};
    assign free_idx      = fdiff_reg >> PAGE_SHIFT;
    assign free_in_range = fge_reg && (free_idx < PHYS_ADDR_W'(eff_count));

    // ------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        region_base_next = region_base_reg;
        frame_count_next = frame_count_reg;
        clr_addr_next    = clr_addr_reg;
        clr_report_next  = clr_report_reg;
        rd_word_next     = rd_word_reg;
        rd_base_next     = rd_base_reg;
        ev_word_next     = ev_word_reg;
        ev_base_next     = ev_base_reg;
        ev_valid_next    = ev_valid_reg;
        fdiff_next       = fdiff_reg;
        fge_next         = fge_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;
        pend_addr_next   = pend_addr_reg;
        pend_status_next = pend_status_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        if (cfg_we) begin
            case (paddr[3])
                REG_REGION_BASE: region_base_next = pwdata;
                REG_FRAME_COUNT: frame_count_next = pwdata[CFG_COUNT_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == END_WORD) begin
                    if (clr_report_reg) begin
                        pend_addr_next   = '0;
                        pend_status_next = ST_CLEARED;
                        state_next       = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        ACT_ALLOC: begin
                            rd_word_next  = '0;
                            rd_base_next  = '0;
                            ev_valid_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        ACT_FREE: begin
                            fdiff_next = sub_wide[PHYS_ADDR_W-1:0];
                            fge_next   = !sub_wide[PHYS_ADDR_W];
                            state_next = S_FCHK;
                        end
                        ACT_CLEAR: begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        default: begin
                            pend_addr_next   = '0;
                            pend_status_next = ST_RANGE;
                            state_next       = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read the next word while the previous one is examined
                mem_re        = issue;
                mem_raddr     = rd_word_reg;
                rd_word_next  = rd_word_reg + 1'b1;
                rd_base_next  = rd_base_reg + BASE_W'(WORD_BITS);
                ev_word_next  = rd_word_reg;
                ev_base_next  = rd_base_reg;
                ev_valid_next = issue;
                if (ev_valid_reg && found) begin
                    mem_we           = 1'b1;
                    mem_waddr        = ev_word_reg;
                    mem_wdata        = mem_rdata_reg | (WORD_BITS'(1) << found_pos);
                    mem_re           = 1'b0;
                    pend_addr_next   = alloc_addr;
                    pend_status_next = ST_ALLOCATED;
                    state_next       = S_DONE;
                end else if (!ev_valid_reg && !issue) begin
                    pend_addr_next   = '0;
                    pend_status_next = ST_OOM;
                    state_next       = S_DONE;
                end
            end
            S_FCHK: begin
                if (free_in_range) begin
                    // split the frame index into word and bit
                    quot_next  = CNT_W'(free_idx >> BIT_W);
                    rem_next   = free_idx[BIT_W-1:0];
                    state_next = S_FRD;
                end else begin
                    pend_addr_next   = '0;
                    pend_status_next = ST_RANGE;
                    state_next       = S_DONE;
                end
            end
            S_FRD: begin
                mem_re     = 1'b1;
                mem_raddr  = quot_reg[WADDR_W-1:0];
                state_next = S_FMOD;
            end
            S_FMOD: begin
                pend_addr_next = '0;
                if (mem_rdata_reg[rem_reg]) begin
                    mem_we           = 1'b1;
                    mem_waddr        = quot_reg[WADDR_W-1:0];
                    mem_wdata        = mem_rdata_reg & ~(WORD_BITS'(1) << rem_reg);
                    pend_status_next = ST_FREED;
                end else begin
                    pend_status_next = ST_ALREADY_FREE;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_addr_reg;
                    m_tuser_next  = pend_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        rd_word_reg     <= rd_word_next;
        rd_base_reg     <= rd_base_next;
        ev_word_reg     <= ev_word_next;
        ev_base_reg     <= ev_base_next;
        fdiff_reg       <= fdiff_next;
        fge_reg         <= fge_next;
        quot_reg        <= quot_next;
        rem_reg         <= rem_next;
        pend_addr_reg   <= pend_addr_next;
        pend_status_reg <= pend_status_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            region_base_reg <= '0;
            frame_count_reg <= FRAME_COUNT_RST;
            clr_addr_reg    <= '0;
            clr_report_reg  <= 1'b0;
            ev_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            region_base_reg <= region_base_next;
            frame_count_reg <= frame_count_next;
            clr_addr_reg    <= clr_addr_next;
            clr_report_reg  <= (state_reg == S_CLEAR && clr_addr_reg == END_WORD)
                               ? 1'b0 : clr_report_next;
            ev_valid_reg    <= ev_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[3])
            REG_REGION_BASE: prdata = region_base_reg;
            REG_FRAME_COUNT: prdata = CFG_DATA_W'(frame_count_reg);
            default:         prdata = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    // an allocate write sets exactly one bit of the word it read
    a_alloc_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == S_SCAN) |->
            ($onehot(mem_wdata ^ mem_rdata_reg) &&
             ((mem_wdata & mem_rdata_reg) == mem_rdata_reg)))
        else $error("allocate write does not set exactly one new bit");

    // a free write clears exactly one bit of the word it read
    a_free_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == S_FMOD) |->
            ($onehot(mem_wdata ^ mem_rdata_reg) &&
             ((mem_wdata | mem_rdata_reg) == mem_rdata_reg)))
        else $error("free write does not clear exactly one bit");

    // out of memory and non-allocate results carry address zero
    a_oom_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_ALLOCATED) |-> (m_tdata == '0))
        else $error("nonzero address on a result other than allocated");

    // the clearing pass stops after the last word
    a_clear_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR && clr_addr_reg == END_WORD) |=> (state_reg != S_CLEAR))
        else $error("clearing pass ran past the last word");

    // a read is never issued in the same cycle as a write
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !mem_re)
        else $error("bitmap read and write in the same cycle");
`endif

endmodule

`default_nettype wire
